// ----- hw/rtl/sols_pkg.sv -----
// Shared types and constants for the self-organizing list search block.
// No dependencies; imported by every module of the block.
package sols_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 8;
  localparam int MODE_W      = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MTF       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } res_t;

endpackage

// ----- hw/rtl/sols_chan_if.sv -----
// Request and result channel interfaces for the list search block.
// Standalone; widths match the fields of sols_pkg.
interface sols_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface sols_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [7:0]  hit_position;
  logic signed [31:0] hit_value;

  modport source (output valid, output status, output hit_position, output hit_value,
                  input ready);
  modport sink   (input valid, input status, input hit_position, input hit_value,
                  output ready);
endinterface

// ----- hw/rtl/self_organizing_list_search.sv -----
// Self-organizing list search, top level. Keeps up to MAX_ENTRIES signed 32-bit
// values in a list memory with one read and one write port and registered reads.
// An append request writes at the end of the list. A search request reads and
// compares one entry at a time from the front; on an empty list it is a miss.
// Move-to-front and transpose reorder through S_SHIFT_RD, S_SHIFT_WR and S_PLACE,
// and every moved entry passes once through the memory's read and write port.
// One request is in flight at a time; a finished result sits in the output
// register while the next request is taken. The user must write search_mode
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block itself
// does not enforce it. Depends on sols_pkg, sols_chan_if, sols_mem and sols_seq.
module self_organizing_list_search (
  input  logic                        clk,
  input  logic                        rst_n,
  sols_in_if.sink                     in_req,
  sols_out_if.source                  out_res,
  input  logic                        cfg_wr_en,
  input  logic [sols_pkg::MODE_W-1:0] cfg_wr_data
);
  import sols_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [DATA_W-1:0] out_value_r;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;
  logic              out_free;

  assign out_free = !out_valid_r || out_res.ready;

  sols_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sols_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_opcode   (in_req.opcode),
    .in_value    (in_req.item_value),
    .search_mode (mode_r),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .out_free    (out_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PLAIN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (out_free) begin
        out_valid_r <= res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_status_r <= res.status;
      out_pos_r    <= res.pos;
      out_value_r  <= res.value;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.hit_position = out_pos_r;
  assign out_res.hit_value    = out_value_r;

endmodule

// ----- hw/rtl/sols_mem.sv -----
// List storage: one write port, one read port with registered read data.
// Depends on sols_pkg.
module sols_mem (
  input  logic                             clk,
  input  sols_pkg::mem_req_t               req,
  output logic [sols_pkg::DATA_W-1:0]      rdata
);
  import sols_pkg::*;

  logic [DATA_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hw/rtl/sols_seq.sv -----
// Sequencer: scans the list with one shared comparator, then reorders it
// through the list memory ports. Depends on sols_pkg and drives sols_mem.
module sols_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [sols_pkg::DATA_W-1:0] in_value,
  input  logic [sols_pkg::MODE_W-1:0] search_mode,
  output sols_pkg::mem_req_t          mem_req,
  input  logic [sols_pkg::DATA_W-1:0] mem_rdata,
  output sols_pkg::res_t              res,
  input  logic                        out_free
);
  import sols_pkg::*;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  status_t           status_r, status_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic in_fire;
  logic full;
  logic match;
  logic last;
  logic reorder;

  assign in_fire = in_valid && (state_r == S_IDLE);
  assign full    = (len_r == LEN_W'(MAX_ENTRIES));
  assign match   = (mem_rdata == key_r);
  assign last    = ((LEN_W'(idx_r) + LEN_W'(1)) == len_r);
  assign reorder = ((search_mode == MODE_MTF) || (search_mode == MODE_TRANSPOSE))
                   && (idx_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_APPEND || len_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ:     state_nxt = S_CMP;
      S_CMP: begin
        priority if (match && reorder) state_nxt = S_SHIFT_RD;
        else if (match || last)        state_nxt = S_DONE;
        else                           state_nxt = S_READ;
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (search_mode == MODE_MTF && idx_r != IDX_W'(1)) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE:    state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    in_ready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = idx_r;
    res.valid     = 1'b0;
    res.status    = status_r;
    res.pos       = pos_r;
    res.value     = val_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          key_nxt = in_value;
          idx_nxt = '0;
          pos_nxt = '0;
          val_nxt = '0;
          if (in_opcode == OP_APPEND) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt    = ST_OK;
              mem_req.we    = 1'b1;
              mem_req.waddr = len_r[IDX_W-1:0];
              mem_req.wdata = in_value;
              len_nxt       = len_r + LEN_W'(1);
            end
          end else begin
            status_nxt = ST_MISS;
          end
        end
      end
      S_READ: begin
        mem_req.raddr = idx_r;
      end
      S_CMP: begin
        if (match) begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(idx_r);
          val_nxt    = mem_rdata;
        end else if (!last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_SHIFT_RD: begin
        mem_req.raddr = idx_r - IDX_W'(1);
      end
      S_SHIFT_WR: begin
        // entry moves back one place
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_r - IDX_W'(1);
      end
      S_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = val_r;
      end
      S_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
  end

endmodule

// ----- hw/rtl/sols_chk.sv -----
// Port-level checker for the list search block, bound to the top level.
// Depends on sols_pkg.
module sols_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [sols_pkg::POS_W-1:0] out_pos,
  input logic [31:0]                out_value
);
  import sols_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_pos)
                                && $stable(out_value))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in flight");

  a_no_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pos == '0 && out_value == '0)
    else $error("miss or full result carries hit data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3 && out_pos < POS_W'(MAX_ENTRIES))
    else $error("bad status or position");

endmodule

bind self_organizing_list_search sols_chk u_sols_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_status (out_res.status),
  .out_pos    (out_res.hit_position),
  .out_value  (out_res.hit_value)
);
